// ----- src/stm_pkg.sv -----
// Shared types and constants of the scrolling text matrix block.
`default_nettype none
package stm_pkg;

  // Display geometry.
  localparam int ROWS         = 5;
  localparam int VISIBLE_COLS = 11;
  localparam int BUFFER_COLS  = 5;
  localparam int STORE_COLS   = (VISIBLE_COLS + BUFFER_COLS) > 16 ? 16
                                : (VISIBLE_COLS + BUFFER_COLS);

  // Glyph and scan word layout.
  localparam int GLYPH_SIZE   = 5;
  localparam int GLYPH_BITS_W = GLYPH_SIZE * GLYPH_SIZE;
  localparam int WORD_W       = 16;
  localparam int ROW_BIT_TOP  = 4;
  localparam int COL_BIT_TOP  = 15;
  localparam int WIDTH_W      = 3;
  localparam int PERIOD_W     = 16;
  localparam int SHIFTS_W     = 3;

  // Word counter inside one tick: ROWS scan words and one trailing word.
  localparam int IDX_W  = $clog2(ROWS + 1);
  localparam int RSEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_WORD    = 1'b1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [STORE_COLS-1:0] store_row_t;

  typedef struct packed {
    logic [GLYPH_BITS_W-1:0] glyph_bits;
    logic                    glyph_valid;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  row_word;
    logic               last_word;
    logic               glyph_taken;
    logic [WIDTH_W-1:0] glyph_width;
    logic               message_end;
  } out_item_t;

  // One classified tick, handed from the front end to the back end.
  typedef struct packed {
    logic [GLYPH_BITS_W-1:0] glyph_bits;
    logic                    glyph_valid;
    logic                    step_now;
    logic [WIDTH_W-1:0]      glyph_width;
  } tick_t;

endpackage
`default_nettype wire

// ----- src/stm_front.sv -----
// Front end: tick phase counter and glyph width classification.
`default_nettype none
module stm_front import stm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire in_item_t            item_i,
  input  wire logic [PERIOD_W-1:0] shift_period_i,
  output tick_t                    tick_o
);

  logic [PERIOD_W-1:0] phase_q, phase_d;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   phase_inc;
  logic                step_now;
  logic [GLYPH_SIZE-1:0] any_col;
  logic [WIDTH_W-1:0]  gw;

  always_comb begin
    period    = (shift_period_i == '0) ? PERIOD_W'(1) : shift_period_i;
    phase_inc = {1'b0, phase_q} + (PERIOD_W+1)'(1);
    step_now  = phase_inc >= {1'b0, period};
    phase_d   = step_now ? '0 : phase_inc[PERIOD_W-1:0];
  end

  // Width is the highest lit column of any row plus one, and at least one.
  always_comb begin
    any_col = '0;
    for (int r = 0; r < GLYPH_SIZE; r++) begin
      any_col = any_col | item_i.glyph_bits[GLYPH_BITS_W-GLYPH_SIZE*(r+1) +: GLYPH_SIZE];
    end
    gw = WIDTH_W'(1);
    for (int c = 0; c < GLYPH_SIZE; c++) begin
      if (any_col[c]) begin
        gw = WIDTH_W'(c + 1);
      end
    end
  end

  always_comb begin
    tick_o.glyph_bits  = item_i.glyph_bits;
    tick_o.glyph_valid = item_i.glyph_valid;
    tick_o.step_now    = step_now;
    tick_o.glyph_width = gw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/stm_queue.sv -----
// Two-entry queue of classified ticks between front end and back end.
`default_nettype none
module stm_queue import stm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire tick_t wr_data_i,
  output logic       full_o,
  input  wire logic  rd_i,
  output tick_t      rd_data_o,
  output logic       empty_o
);

  tick_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/stm_back.sv -----
// Back end: pixel store, scan word generation, scroll and glyph write.
`default_nettype none
module stm_back import stm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tick_t             tick_i,
  input  wire logic              tick_empty_i,
  output logic                   tick_rd_o,
  input  wire logic [WORD_W-1:0] idle_word_i,
  output out_item_t              out_o,
  output logic                   out_empty_o,
  input  wire logic              out_pop_i
);

  store_row_t rows_q [ROWS];
  store_row_t rows_d [ROWS];
  store_row_t rot    [ROWS];
  store_row_t gdat   [ROWS];
  store_row_t wmask;
  store_row_t cur_row;
  logic [IDX_W-1:0]    idx_q;
  logic [RSEL_W-1:0]   rsel;
  logic [SHIFTS_W-1:0] sd_q, sd_inc;
  logic                out_valid_q;
  out_item_t           out_q, out_d;
  logic                advance, at_last, step_eff, take;
  logic [WORD_W-1:0]   scan_word, clr_mask;
  logic [GLYPH_SIZE-1:0] grow;

  assign at_last     = idx_q == IDX_W'(ROWS);
  assign advance     = !tick_empty_i && (!out_valid_q || out_pop_i);
  assign tick_rd_o   = advance && at_last;
  assign out_o       = out_q;
  assign out_empty_o = !out_valid_q;

  // Scan word of the row under the word counter.
  always_comb begin
    rsel    = at_last ? '0 : idx_q[RSEL_W-1:0];
    cur_row = rows_q[rsel];
    clr_mask = '0;
    for (int c = 0; c < VISIBLE_COLS; c++) begin
      clr_mask[COL_BIT_TOP-c] = cur_row[c];
    end
    scan_word = idle_word_i & ~clr_mask;
    if (|cur_row[VISIBLE_COLS-1:0]) begin
      scan_word[4'(ROW_BIT_TOP) - 4'(rsel)] = 1'b1;
    end
  end

  // Store update at the end of the tick: rotate, then write the glyph.
  always_comb begin
    step_eff = tick_i.glyph_valid && tick_i.step_now;
    sd_inc   = step_eff ? sd_q + SHIFTS_W'(1) : sd_q;
    take     = tick_i.glyph_valid && (sd_inc >= tick_i.glyph_width);
    wmask    = '0;
    for (int c = 0; c < GLYPH_SIZE; c++) begin
      if ((VISIBLE_COLS - 1 + c) < STORE_COLS) begin
        wmask[VISIBLE_COLS-1+c] =
          ({1'b0, 3'(c)} + {1'b0, tick_i.glyph_width}) >= 4'(GLYPH_SIZE);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      rot[r]  = step_eff ? {rows_q[r][0], rows_q[r][STORE_COLS-1:1]} : rows_q[r];
      grow    = tick_i.glyph_bits[GLYPH_BITS_W-GLYPH_SIZE*(r+1) +: GLYPH_SIZE];
      gdat[r] = '0;
      for (int c = 0; c < GLYPH_SIZE; c++) begin
        if ((VISIBLE_COLS - 1 + c) < STORE_COLS) begin
          gdat[r][VISIBLE_COLS-1+c] = grow[GLYPH_SIZE-1-c];
        end
      end
      rows_d[r] = take ? ((rot[r] & ~wmask) | (gdat[r] & wmask)) : rot[r];
    end
  end

  always_comb begin
    out_d.row_word    = at_last ? idle_word_i : scan_word;
    out_d.last_word   = at_last;
    out_d.glyph_taken = at_last && take;
    out_d.glyph_width = (at_last && take) ? tick_i.glyph_width : '0;
    out_d.message_end = at_last && !tick_i.glyph_valid;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sd_q        <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        rows_q[r] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (at_last) begin
          idx_q <= '0;
          sd_q  <= take ? '0 : sd_inc;
          for (int r = 0; r < ROWS; r++) begin
            rows_q[r] <= rows_d[r];
          end
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/scrolling_text_matrix_top.sv -----
// Top level of the scrolling text matrix: configuration registers and wiring.
`default_nettype none
// Each transfer pushed into this block is one display tick carrying a 5x5 glyph
// or an end-of-message mark (glyph_valid low). For every tick the block delivers
// six result transfers: five row scan words built from the visible part of the
// pixel store as it stood before the tick, then the idle word with last_word set,
// which also reports whether the glyph was taken (and its width) and whether an
// end mark was seen. Scrolling and the glyph write take effect after the last
// word has been produced, so they show in the next tick's scan words. The
// sustained tick rate is set by the back end, which loads one scan word per
// cycle into its output register while that register is empty or being popped;
// the first scan word of a tick passes through the queue and then the output
// register. A front end keeps the tick phase and measures the glyph width
// at push time and hands the tick to the back end through a two-entry queue. The
// tick being scanned stays in that queue until its last word is loaded, so the
// queue holds that tick and at most one more waiting behind it while the
// consumer stalls. shift_period (address 0) and idle_word (address 4) should be
// written only while the block is idle; a shift_period of zero acts as one.
module scrolling_text_matrix_top import stm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Tick input queue side.
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_data_i,
  // Result queue side.
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_data_o,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [PERIOD_W-1:0] shift_period_q;
  logic [WORD_W-1:0]   idle_word_q;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                cfg_wr;
  logic                in_accept;
  tick_t               tick_wr, tick_rd;
  logic                q_full, q_empty, q_rd;

  // Configuration registers sit on word addresses; every access completes at once.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2 +: CFG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_SHIFT_PERIOD: prdata = {{(PDATA_W-PERIOD_W){1'b0}}, shift_period_q};
      REG_IDLE_WORD:    prdata = {{(PDATA_W-WORD_W){1'b0}}, idle_word_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_period_q <= PERIOD_W'(1);
      idle_word_q    <= WORD_W'(16'hFFE0);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHIFT_PERIOD: shift_period_q <= pwdata[PERIOD_W-1:0];
        REG_IDLE_WORD:    idle_word_q    <= pwdata[WORD_W-1:0];
        default:          ;
      endcase
    end
  end

  // A tick is taken whenever the queue to the back end has room.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  stm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .item_i         (in_data_i),
    .shift_period_i (shift_period_q),
    .tick_o         (tick_wr)
  );

  stm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (in_accept),
    .wr_data_i (tick_wr),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (tick_rd),
    .empty_o   (q_empty)
  );

  // The back end's output register is the result queue's head.
  stm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_rd),
    .tick_empty_i (q_empty),
    .tick_rd_o    (q_rd),
    .idle_word_i  (idle_word_q),
    .out_o        (out_data_o),
    .out_empty_o  (empty),
    .out_pop_i    (pop)
  );

endmodule
`default_nettype wire
